// File: hdl/mba_pkg.sv
// Shared types and constants for the mesh bounds and area accumulator.
// No dependencies; every other file in hdl/ uses it.
package mba_pkg;

  localparam int CoordWidth = 24;
  localparam int FracBits   = 16;
  localparam int AreaWidth  = 63;
  localparam int QueueDepth = 2;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    logic   first_of_mesh;
    coord_t ax;
    coord_t ay;
    coord_t az;
    coord_t bx;
    coord_t by_coord;
    coord_t bz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
  } in_item_t;

  typedef struct packed {
    coord_t                 min_x;
    coord_t                 min_y;
    coord_t                 min_z;
    coord_t                 max_x;
    coord_t                 max_y;
    coord_t                 max_z;
    logic [AreaWidth-1:0]   area_total;
    logic                   area_saturated;
  } out_item_t;

  // Classified triangle handed from the area front to the accumulate back.
  typedef struct packed {
    logic                 first;
    coord_t [2:0]         va;
    coord_t [2:0]         vb;
    coord_t [2:0]         vc;
    logic [AreaWidth-1:0] tri_area;
    logic                 over;
  } work_item_t;

endpackage

// File: hdl/mba_front.sv
// Area front: takes a triangle, computes the floored cross product norm.
// Uses mba_pkg; feeds mba_queue.
module mba_front #(
  parameter int FRAC_BITS = mba_pkg::FracBits
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  mba_pkg::in_item_t   in_item,
  output logic                wr_en,
  output mba_pkg::work_item_t wr_item,
  input  logic                wr_full
);

  localparam int CW   = mba_pkg::CoordWidth;
  localparam int EW   = CW + 1;
  localparam int PW   = 2 * EW;
  localparam int MW   = 2 * CW + 1;
  localparam int LW   = (MW + 1) / 2;
  localparam int HW   = MW - LW;
  localparam int SW   = 2 * MW + 2;
  localparam int RW   = MW + 1;
  localparam int CNTW = $clog2(RW + 1);
  localparam int SH   = 31 - 2 * FRAC_BITS;
  localparam int SHL  = (SH >= 0) ? SH : 0;
  localparam int SHR  = (SH < 0) ? -SH : 0;
  localparam int AW   = (RW + 31 > 64) ? RW + 31 : 64;
  localparam int XW   = mba_pkg::AreaWidth;

  typedef enum logic [2:0] {
    S_IDLE, S_EDGE, S_PROD, S_DIFF, S_SQ, S_CMB, S_ROOT, S_OUT
  } state_t;

  state_t                 state_r;
  mba_pkg::in_item_t      item_r;
  logic signed [EW-1:0]   e_r [3];
  logic signed [EW-1:0]   f_r [3];
  logic signed [PW-1:0]   prod_r [6];
  logic [MW-1:0]          mag_r [3];
  logic [2*HW-1:0]        hh_r [3];
  logic [HW+LW-1:0]       hl_r [3];
  logic [2*LW-1:0]        ll_r [3];
  logic [SW-1:0]          sq_r [3];
  logic [SW-1:0]          sum_r;
  logic [RW+1:0]          rem_r;
  logic [RW-1:0]          root_r;
  logic [CNTW-1:0]        cnt_r;

  logic signed [PW:0]     diff [3];
  logic signed [PW:0]     diff_abs [3];
  logic [MW-1:0]          mag_nxt [3];
  logic [SW-1:0]          sq_nxt [3];
  logic [RW+1:0]          rem_shift;
  logic [RW+1:0]          trial;
  logic [AW-1:0]          area_ext;

  always_comb begin
    diff[0] = (PW+1)'(prod_r[0]) - (PW+1)'(prod_r[1]);
    diff[1] = (PW+1)'(prod_r[2]) - (PW+1)'(prod_r[3]);
    diff[2] = (PW+1)'(prod_r[4]) - (PW+1)'(prod_r[5]);
    for (int k = 0; k < 3; k++) begin
      diff_abs[k] = diff[k][PW] ? -diff[k] : diff[k];
      mag_nxt[k]  = MW'(diff_abs[k]);
      // c^2 = hh << 2L + hl << (L+1) + ll
      sq_nxt[k]   = (SW'(hh_r[k]) << (2 * LW)) + (SW'(hl_r[k]) << (LW + 1)) + SW'(ll_r[k]);
    end
    rem_shift = {rem_r[RW-1:0], sum_r[SW-1:SW-2]};
    trial     = {root_r, 2'b01};
    area_ext  = (AW'(root_r) << SHL) >> SHR;
  end

  assign full  = (state_r != S_IDLE);
  assign wr_en = (state_r == S_OUT) && !wr_full;

  always_comb begin
    wr_item          = '0;
    wr_item.first    = item_r.first_of_mesh;
    wr_item.va       = {item_r.az, item_r.ay, item_r.ax};
    wr_item.vb       = {item_r.bz, item_r.by_coord, item_r.bx};
    wr_item.vc       = {item_r.cz, item_r.cy, item_r.cx};
    wr_item.tri_area = area_ext[XW-1:0];
    wr_item.over     = |area_ext[AW-1:XW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (push) begin
            item_r  <= in_item;
            state_r <= S_EDGE;
          end
        end
        S_EDGE: begin
          e_r[0] <= EW'(item_r.bx) - EW'(item_r.ax);
          e_r[1] <= EW'(item_r.by_coord) - EW'(item_r.ay);
          e_r[2] <= EW'(item_r.bz) - EW'(item_r.az);
          f_r[0] <= EW'(item_r.cx) - EW'(item_r.ax);
          f_r[1] <= EW'(item_r.cy) - EW'(item_r.ay);
          f_r[2] <= EW'(item_r.cz) - EW'(item_r.az);
          state_r <= S_PROD;
        end
        S_PROD: begin
          prod_r[0] <= e_r[1] * f_r[2];
          prod_r[1] <= e_r[2] * f_r[1];
          prod_r[2] <= e_r[2] * f_r[0];
          prod_r[3] <= e_r[0] * f_r[2];
          prod_r[4] <= e_r[0] * f_r[1];
          prod_r[5] <= e_r[1] * f_r[0];
          state_r   <= S_DIFF;
        end
        S_DIFF: begin
          for (int k = 0; k < 3; k++) mag_r[k] <= mag_nxt[k];
          state_r <= S_SQ;
        end
        S_SQ: begin
          for (int k = 0; k < 3; k++) begin
            hh_r[k] <= (2*HW)'(mag_r[k][MW-1:LW]) * (2*HW)'(mag_r[k][MW-1:LW]);
            hl_r[k] <= (HW+LW)'(mag_r[k][MW-1:LW]) * (HW+LW)'(mag_r[k][LW-1:0]);
            ll_r[k] <= (2*LW)'(mag_r[k][LW-1:0]) * (2*LW)'(mag_r[k][LW-1:0]);
          end
          state_r <= S_CMB;
        end
        S_CMB: begin
          for (int k = 0; k < 3; k++) sq_r[k] <= sq_nxt[k];
          state_r <= S_ROOT;
          cnt_r   <= '0;
          sum_r   <= '0;
        end
        S_ROOT: begin
          if (cnt_r == '0) begin
            // first cycle here: load the squared norm, clear the root
            sum_r  <= sq_r[0] + sq_r[1] + sq_r[2];
            rem_r  <= '0;
            root_r <= '0;
            cnt_r  <= CNTW'(RW);
          end else begin
            // restoring square root, one root bit per cycle
            sum_r <= sum_r << 2;
            if (rem_shift >= trial) begin
              rem_r  <= rem_shift - trial;
              root_r <= {root_r[RW-2:0], 1'b1};
            end else begin
              rem_r  <= rem_shift;
              root_r <= {root_r[RW-2:0], 1'b0};
            end
            cnt_r <= cnt_r - 1'b1;
            if (cnt_r == CNTW'(1)) state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!wr_full) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/mba_queue.sv
// Short queue between the area front and the accumulate back.
// Uses mba_pkg for the work item type.
module mba_queue #(
  parameter int DEPTH = mba_pkg::QueueDepth
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  mba_pkg::work_item_t wr_item,
  output logic                wr_full,
  input  logic                rd_en,
  output mba_pkg::work_item_t rd_item,
  output logic                rd_empty
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mba_pkg::work_item_t mem_r [DEPTH];
  logic [IW-1:0]       wp_r;
  logic [IW-1:0]       rp_r;
  logic [CW-1:0]       cnt_r;

  assign wr_full  = (cnt_r == CW'(DEPTH));
  assign rd_empty = (cnt_r == '0);
  assign rd_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == IW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == IW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CW'(wr_en) - CW'(rd_en);
    end
  end

endmodule

// File: hdl/mba_back.sv
// Accumulate back: grows the box, adds the triangle area, holds the result.
// Uses mba_pkg; reads from mba_queue.
module mba_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mba_pkg::work_item_t rd_item,
  input  logic                rd_empty,
  output logic                rd_en,
  input  logic                pop,
  output logic                empty,
  output mba_pkg::out_item_t  out_item
);

  localparam int XW = mba_pkg::AreaWidth;

  mba_pkg::coord_t    box_min_r [3];
  mba_pkg::coord_t    box_max_r [3];
  logic [XW-1:0]      area_r;
  logic               box_valid_r;
  logic               sat_r;
  logic               out_valid_r;
  mba_pkg::out_item_t out_item_r;

  mba_pkg::coord_t    min_nxt [3];
  mba_pkg::coord_t    max_nxt [3];
  logic [XW-1:0]      area_base;
  logic [XW:0]        area_sum;
  logic [XW-1:0]      area_nxt;
  logic               sat_nxt;
  logic               seeded;

  assign rd_en    = !rd_empty && (!out_valid_r || pop);
  assign empty    = !out_valid_r;
  assign out_item = out_item_r;

  always_comb begin
    seeded = box_valid_r && !rd_item.first;
    for (int k = 0; k < 3; k++) begin
      min_nxt[k] = rd_item.va[k];
      max_nxt[k] = rd_item.va[k];
      if (seeded && box_min_r[k] < min_nxt[k]) min_nxt[k] = box_min_r[k];
      if (seeded && box_max_r[k] > max_nxt[k]) max_nxt[k] = box_max_r[k];
      if (rd_item.vb[k] < min_nxt[k]) min_nxt[k] = rd_item.vb[k];
      if (rd_item.vb[k] > max_nxt[k]) max_nxt[k] = rd_item.vb[k];
      if (rd_item.vc[k] < min_nxt[k]) min_nxt[k] = rd_item.vc[k];
      if (rd_item.vc[k] > max_nxt[k]) max_nxt[k] = rd_item.vc[k];
    end
    area_base = rd_item.first ? '0 : area_r;
    area_sum  = {1'b0, area_base} + {1'b0, rd_item.tri_area};
    if (rd_item.over || area_sum[XW]) begin
      area_nxt = '1;
      sat_nxt  = 1'b1;
    end else begin
      area_nxt = area_sum[XW-1:0];
      sat_nxt  = sat_r && !rd_item.first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_valid_r <= 1'b0;
      sat_r       <= 1'b0;
      area_r      <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        box_min_r[k] <= '0;
        box_max_r[k] <= '0;
      end
    end else begin
      if (rd_en) begin
        box_valid_r <= 1'b1;
        sat_r       <= sat_nxt;
        area_r      <= area_nxt;
        out_valid_r <= 1'b1;
        for (int k = 0; k < 3; k++) begin
          box_min_r[k] <= min_nxt[k];
          box_max_r[k] <= max_nxt[k];
        end
        out_item_r.min_x          <= min_nxt[0];
        out_item_r.min_y          <= min_nxt[1];
        out_item_r.min_z          <= min_nxt[2];
        out_item_r.max_x          <= max_nxt[0];
        out_item_r.max_y          <= max_nxt[1];
        out_item_r.max_z          <= max_nxt[2];
        out_item_r.area_total     <= area_nxt;
        out_item_r.area_saturated <= sat_nxt;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.area_saturated |-> &out_item_r.area_total)
    else $error("saturated result without clipped area");

  a_area_grows: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && !rd_item.first |=> area_r >= $past(area_r))
    else $error("area shrank within a mesh");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    box_valid_r |-> (box_min_r[0] <= box_max_r[0]) && (box_min_r[1] <= box_max_r[1])
                    && (box_min_r[2] <= box_max_r[2]))
    else $error("box minimum above maximum");
`endif

endmodule

// File: hdl/mesh_bounds_area_accumulator.sv
// Top level of the mesh bounds and area accumulator.
// Instantiates mba_front, mba_queue and mba_back; uses mba_pkg.
//
// Takes one triangle per request (three signed fixed-point vertices) and
// returns, per triangle, the running axis-aligned bounding box and the running
// surface area (63-bit unsigned, 32 fraction bits, saturating with a sticky
// flag). first_of_mesh restarts box, area and flag before that triangle.
// Timing: the area front handles one triangle at a time. After a request is
// accepted, full stays high through five arithmetic steps, a load step, the
// bit-serial square root (one root bit per cycle, 2 * CoordWidth + 2 root
// bits) and a hand-off into the queue, which is held while the queue is full.
// The next request is taken once the front is back in idle, so the front does
// not take a new triangle before the last one is in the queue. A two-entry
// queue decouples the front from the accumulate back, which updates the box
// and the sum as it reads each triangle and holds the result in an output
// register until popped, so a waiting result does not stop the next triangle
// from entering while the queue has room.
module mesh_bounds_area_accumulator #(
  parameter int FRAC_BITS   = mba_pkg::FracBits,
  parameter int QUEUE_DEPTH = mba_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  // triangle requests
  input  logic               push,
  output logic               full,
  input  mba_pkg::in_item_t  in_item,
  // results
  output logic               empty,
  input  logic               pop,
  output mba_pkg::out_item_t out_item
);

  mba_pkg::work_item_t wr_item;
  mba_pkg::work_item_t rd_item;
  logic                wr_en;
  logic                wr_full;
  logic                rd_en;
  logic                rd_empty;

  // front: edges, cross product, squared norm, square root
  mba_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .wr_en   (wr_en),
    .wr_item (wr_item),
    .wr_full (wr_full)
  );

  // short queue so each side stalls on its own
  mba_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_item  (wr_item),
    .wr_full  (wr_full),
    .rd_en    (rd_en),
    .rd_item  (rd_item),
    .rd_empty (rd_empty)
  );

  // back: box growth, saturating area sum, output register
  mba_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_item  (rd_item),
    .rd_empty (rd_empty),
    .rd_en    (rd_en),
    .pop      (pop),
    .empty    (empty),
    .out_item (out_item)
  );

endmodule
